### design/tcf_pkg.sv
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared types and constants for the two-class oldest-first FIFO.
// ----------------------------------------------------------------------------
package tcf_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 16;
    localparam int STAMP_W     = 6;
    localparam int PREF_W      = 2;

    localparam logic ACT_ADMIT = 1'b0;
    localparam logic ACT_ADOPT = 1'b1;

    localparam logic [PREF_W-1:0] PREF_ANY = 2'd0;
    localparam logic [PREF_W-1:0] PREF_A   = 2'd1;
    localparam logic [PREF_W-1:0] PREF_B   = 2'd2;

    typedef enum logic [1:0] {
        ST_ADOPTED  = 2'd0,
        ST_ADMITTED = 2'd1,
        ST_NO_MATCH = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic read;
        logic exec;
    } t_ctl_cmd;

endpackage

### design/two_class_fifo_oldest_first.sv
// ----------------------------------------------------------------------------
// two_class_fifo_oldest_first
// Two FIFOs of signed identifiers with oldest-first removal across classes.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request goes
// through the accept edge, a registered read of both queue heads, and an
// execute step that updates the queues. The result appears on o_status and
// o_adopted_id with o_strobe, which is registered from the execute step, high
// for exactly one cycle, and busy is already low in that cycle, so the next
// request can be taken while the result is shown. There is no way to
// stall the result: the receiver must take it in the strobe cycle.
module two_class_fifo_oldest_first (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_action,
    input  logic signed [tcf_pkg::ID_W-1:0] i_animal_id,
    input  logic [tcf_pkg::PREF_W-1:0]      i_preference,
    output logic                            o_strobe,
    output logic [1:0]                      o_status,
    output logic signed [tcf_pkg::ID_W-1:0] o_adopted_id
);
    import tcf_pkg::*;

    t_ctl_cmd cmd;

    tcf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    tcf_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_action     (i_action),
        .i_animal_id  (i_animal_id),
        .i_preference (i_preference),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_adopted_id (o_adopted_id)
    );

endmodule

### design/tcf_ctrl.sv
// ----------------------------------------------------------------------------
// tcf_ctrl
// Sequencer: accept a request, read the queue heads, then execute.
// ----------------------------------------------------------------------------
module tcf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output tcf_pkg::t_ctl_cmd o_cmd
);
    import tcf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_EXEC;
            S_EXEC: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_cmd.capture = i_start && (r_state == S_IDLE);
    assign o_cmd.read    = (r_state == S_READ);
    assign o_cmd.exec    = (r_state == S_EXEC);

    a_capture_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.read)
        else $error("capture not followed by head read");

    a_read_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.read |=> o_cmd.exec)
        else $error("head read not followed by execute");

    a_exec_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> !o_busy)
        else $error("busy held after execute");

endmodule

### design/tcf_datapath.sv
// ----------------------------------------------------------------------------
// tcf_datapath
// Two queue stores with stamps, head/count registers, arrival counter and
// the oldest-first selection.
// ----------------------------------------------------------------------------
module tcf_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tcf_pkg::t_ctl_cmd              i_cmd,
    input  logic                           i_action,
    input  logic signed [tcf_pkg::ID_W-1:0] i_animal_id,
    input  logic [tcf_pkg::PREF_W-1:0]     i_preference,
    output logic                           o_strobe,
    output logic [1:0]                     o_status,
    output logic signed [tcf_pkg::ID_W-1:0] o_adopted_id
);
    import tcf_pkg::*;

    localparam int SUM_W = CNT_W + 1;

    // Queue storage
    logic [ID_W-1:0]    r_a_ids    [QUEUE_DEPTH];
    logic [STAMP_W-1:0] r_a_stamps [QUEUE_DEPTH];
    logic [ID_W-1:0]    r_b_ids    [QUEUE_DEPTH];
    logic [STAMP_W-1:0] r_b_stamps [QUEUE_DEPTH];

    logic [ADDR_W-1:0]  r_a_head, r_b_head, n_a_head, n_b_head;
    logic [CNT_W-1:0]   r_a_count, r_b_count, n_a_count, n_b_count;
    logic [STAMP_W-1:0] r_arrival, n_arrival;

    // Captured request
    logic               r_action;
    logic signed [ID_W-1:0] r_id;
    logic [PREF_W-1:0]  r_pref;

    // Registered head reads
    logic [ID_W-1:0]    r_a_id_rd, r_b_id_rd;
    logic [STAMP_W-1:0] r_a_st_rd, r_b_st_rd;

    logic               r_strobe;
    t_status            r_status, n_status;
    logic [ID_W-1:0]    r_adopted, n_adopted;

    logic               is_class_a;
    logic               wr_a, wr_b;
    logic [ADDR_W-1:0]  a_tail, b_tail;
    logic [SUM_W-1:0]   a_sum, b_sum;
    logic [STAMP_W-1:0] stamp_diff;
    logic               pick_a, pick_b;

    always_comb begin
        a_sum = SUM_W'(r_a_head) + SUM_W'(r_a_count);
        b_sum = SUM_W'(r_b_head) + SUM_W'(r_b_count);
        // wrap tail: sum stays below twice the depth
        if (a_sum >= SUM_W'(QUEUE_DEPTH)) begin
            a_sum = a_sum - SUM_W'(QUEUE_DEPTH);
        end
        if (b_sum >= SUM_W'(QUEUE_DEPTH)) begin
            b_sum = b_sum - SUM_W'(QUEUE_DEPTH);
        end
        a_tail = a_sum[ADDR_W-1:0];
        b_tail = b_sum[ADDR_W-1:0];
    end

    assign is_class_a = (r_id > 0);
    assign stamp_diff = r_b_st_rd - r_a_st_rd;

    always_comb begin
        pick_a = 1'b0;
        pick_b = 1'b0;
        priority if (r_pref == PREF_A) begin
            pick_a = (r_a_count != '0);
        end else if (r_pref == PREF_B) begin
            pick_b = (r_b_count != '0);
        end else if (r_pref == PREF_ANY) begin
            if (r_a_count != '0 && r_b_count != '0) begin
                // B head is older when the wrapped difference is negative
                pick_b = stamp_diff[STAMP_W-1];
                pick_a = !stamp_diff[STAMP_W-1];
            end else begin
                pick_a = (r_a_count != '0);
                pick_b = (r_b_count != '0);
            end
        end else begin
            pick_a = 1'b0;
        end
    end

    always_comb begin
        n_a_head  = r_a_head;
        n_b_head  = r_b_head;
        n_a_count = r_a_count;
        n_b_count = r_b_count;
        n_arrival = r_arrival;
        n_status  = ST_NO_MATCH;
        n_adopted = '0;
        wr_a      = 1'b0;
        wr_b      = 1'b0;
        if (r_action == ACT_ADMIT) begin
            if (is_class_a) begin
                if (r_a_count >= CNT_W'(QUEUE_DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    wr_a      = 1'b1;
                    n_a_count = r_a_count + 1'b1;
                    n_arrival = r_arrival + 1'b1;
                    n_status  = ST_ADMITTED;
                end
            end else begin
                if (r_b_count >= CNT_W'(QUEUE_DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    wr_b      = 1'b1;
                    n_b_count = r_b_count + 1'b1;
                    n_arrival = r_arrival + 1'b1;
                    n_status  = ST_ADMITTED;
                end
            end
        end else begin
            if (pick_a) begin
                n_adopted = r_a_id_rd;
                n_a_count = r_a_count - 1'b1;
                n_a_head  = (r_a_head == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : r_a_head + 1'b1;
                n_status  = ST_ADOPTED;
            end else if (pick_b) begin
                n_adopted = r_b_id_rd;
                n_b_count = r_b_count - 1'b1;
                n_b_head  = (r_b_head == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : r_b_head + 1'b1;
                n_status  = ST_ADOPTED;
            end
        end
    end

    // Storage write and registered head read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_a) begin
            r_a_ids[a_tail]    <= r_id;
            r_a_stamps[a_tail] <= r_arrival;
        end
        if (i_cmd.exec && wr_b) begin
            r_b_ids[b_tail]    <= r_id;
            r_b_stamps[b_tail] <= r_arrival;
        end
        if (i_cmd.read) begin
            r_a_id_rd <= r_a_ids[r_a_head];
            r_a_st_rd <= r_a_stamps[r_a_head];
            r_b_id_rd <= r_b_ids[r_b_head];
            r_b_st_rd <= r_b_stamps[r_b_head];
        end
    end

    // Request capture and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_id     <= i_animal_id;
            r_pref   <= i_preference;
        end
        if (i_cmd.exec) begin
            r_status  <= n_status;
            r_adopted <= n_adopted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_head  <= '0;
            r_b_head  <= '0;
            r_a_count <= '0;
            r_b_count <= '0;
            r_arrival <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_strobe <= i_cmd.exec;
            if (i_cmd.exec) begin
                r_a_head  <= n_a_head;
                r_b_head  <= n_b_head;
                r_a_count <= n_a_count;
                r_b_count <= n_b_count;
                r_arrival <= n_arrival;
            end
        end
    end

    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_adopted_id = r_adopted;

    a_a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_count <= CNT_W'(QUEUE_DEPTH))
        else $error("class A count over depth");

    a_b_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_count <= CNT_W'(QUEUE_DEPTH))
        else $error("class B count over depth");

    a_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_ADOPTED) |-> (o_adopted_id == '0))
        else $error("identifier nonzero on non-adopt result");

    a_exec_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> o_strobe)
        else $error("execute without result strobe");

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-class oldest-first FIFO. A behavioral
// shelter model predicts the status and removed identifier of every request;
// each strobed result is compared with the oldest prediction. Directed
// requests hit empty queues, a full queue and cross-class age ordering, then
// biased random traffic fills and drains both classes with random gaps.
// ----------------------------------------------------------------------------
module testbench;
    import tcf_pkg::*;

    localparam int CLS_A = 0;
    localparam int CLS_B = 1;
    localparam int RANDOM_REQUESTS = 1900;

    // Preference code with no meaning: the adopt is ignored
    localparam logic [PREF_W-1:0] PREF_NONE = 2'd3;

    typedef struct packed {
        t_status                status;
        logic signed [ID_W-1:0] adopted_id;
    } t_outcome;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   start        = 1'b0;
    logic                   i_action     = ACT_ADMIT;
    logic signed [ID_W-1:0] i_animal_id  = '0;
    logic [PREF_W-1:0]      i_preference = PREF_ANY;
    logic                   busy;
    logic                   o_strobe;
    logic [1:0]             o_status;
    logic signed [ID_W-1:0] o_adopted_id;

    // Shelter model state, indexed by class
    logic signed [ID_W-1:0] held_id    [2][QUEUE_DEPTH];
    logic [STAMP_W-1:0]     held_stamp [2][QUEUE_DEPTH];
    int                     head  [2];
    int                     count [2];
    logic [STAMP_W-1:0]     next_stamp;

    t_outcome outcome_q[$];
    int       err_count   = 0;
    bit       idle_enable = 1'b1;

    two_class_fifo_oldest_first u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_animal_id  (i_animal_id),
        .i_preference (i_preference),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_adopted_id (o_adopted_id)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("two_class_fifo_oldest_first test failed");
        $finish;
    end

    function automatic t_outcome predict_outcome(input logic act,
                                                 input logic signed [ID_W-1:0] id,
                                                 input logic [PREF_W-1:0] pref);
        t_outcome           res;
        int                 cls;
        int                 pick;
        logic [STAMP_W-1:0] age_gap;
        res.status     = ST_NO_MATCH;
        res.adopted_id = '0;
        pick           = -1;
        if (act == ACT_ADMIT) begin
            cls = (id > 0) ? CLS_A : CLS_B;
            if (count[cls] >= QUEUE_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                held_id[cls][(head[cls] + count[cls]) % QUEUE_DEPTH]    = id;
                held_stamp[cls][(head[cls] + count[cls]) % QUEUE_DEPTH] = next_stamp;
                count[cls] = count[cls] + 1;
                next_stamp = next_stamp + 1'b1;
                res.status = ST_ADMITTED;
            end
        end else begin
            case (pref)
                PREF_A: begin
                    if (count[CLS_A] != 0) pick = CLS_A;
                end
                PREF_B: begin
                    if (count[CLS_B] != 0) pick = CLS_B;
                end
                PREF_ANY: begin
                    if (count[CLS_A] == 0 && count[CLS_B] != 0) begin
                        pick = CLS_B;
                    end else if (count[CLS_B] == 0 && count[CLS_A] != 0) begin
                        pick = CLS_A;
                    end else if (count[CLS_A] != 0 && count[CLS_B] != 0) begin
                        // B is older when its stamp trails A's by at most half the ring
                        age_gap = held_stamp[CLS_B][head[CLS_B]]
                                - held_stamp[CLS_A][head[CLS_A]];
                        pick = age_gap[STAMP_W-1] ? CLS_B : CLS_A;
                    end
                end
                default: ;
            endcase
            if (pick >= 0) begin
                res.status     = ST_ADOPTED;
                res.adopted_id = held_id[pick][head[pick]];
                head[pick]     = (head[pick] + 1) % QUEUE_DEPTH;
                count[pick]    = count[pick] - 1;
            end
        end
        return res;
    endfunction

    // Hold start high until the request is taken; leave it high unless idling
    task automatic send_request(input logic act, input logic signed [ID_W-1:0] id,
                                input logic [PREF_W-1:0] pref);
        start        <= 1'b1;
        i_action     <= act;
        i_animal_id  <= id;
        i_preference <= pref;
        do @(posedge i_clk); while (busy);
        outcome_q.push_back(predict_outcome(act, id, pref));
        if (idle_enable && $urandom_range(99) < 19) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Always advance to a clock edge so start is never driven twice in a step
    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge i_clk); while (outcome_q.size() != 0);
    endtask

    task automatic test_empty_requests();
        send_request(ACT_ADOPT, 16'sd0, PREF_ANY);
        send_request(ACT_ADOPT, 16'sd0, PREF_A);
        send_request(ACT_ADOPT, 16'sd0, PREF_B);
        send_request(ACT_ADOPT, 16'sd0, PREF_NONE);
        wait_for_results();
    endtask

    task automatic test_class_order();
        send_request(ACT_ADMIT, 16'sh7FFF, PREF_ANY);
        send_request(ACT_ADMIT, 16'sd0, PREF_B);
        send_request(ACT_ADMIT, -16'sh8000, PREF_NONE);
        send_request(ACT_ADMIT, 16'sd1, PREF_A);
        send_request(ACT_ADMIT, -16'sd1, PREF_ANY);
        send_request(ACT_ADOPT, 16'sd0, PREF_NONE);
        send_request(ACT_ADOPT, -16'sd1, PREF_ANY);
        send_request(ACT_ADOPT, 16'sh7FFF, PREF_B);
        send_request(ACT_ADOPT, 16'sd0, PREF_ANY);
        send_request(ACT_ADOPT, 16'sd0, PREF_A);
        send_request(ACT_ADOPT, 16'sd0, PREF_ANY);
        wait_for_results();
    endtask

    // Fill class A and push one more to force a drop; random traffic drains it
    task automatic test_full_queue();
        repeat (QUEUE_DEPTH + 1)
            send_request(ACT_ADMIT, ID_W'($urandom_range(1, 32767)), PREF_ANY);
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        int                     admit_bias;
        logic                   act;
        logic signed [ID_W-1:0] id;
        logic [PREF_W-1:0]      pref;
        admit_bias = 50;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            // Swing the admit/adopt mix so both queues run full and empty
            if (n % 100 == 0) begin
                case ($urandom_range(2))
                    0:       admit_bias = 15;
                    1:       admit_bias = 50;
                    default: admit_bias = 85;
                endcase
            end
            if (n % 500 == 499) wait_for_results();
            idle_enable = !(n >= 700 && n < 1000);
            act = ($urandom_range(99) < admit_bias) ? ACT_ADMIT : ACT_ADOPT;
            case ($urandom_range(9))
                0:       id = 16'sd0;
                1:       id = 16'sd1;
                2:       id = -16'sd1;
                3:       id = 16'sh7FFF;
                4:       id = -16'sh8000;
                default: id = ID_W'($urandom);
            endcase
            pref = ($urandom_range(99) < 5) ? PREF_NONE : PREF_W'($urandom_range(2));
            send_request(act, id, pref);
        end
        idle_enable = 1'b1;
        wait_for_results();
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_strobe) begin
            if (outcome_q.size() == 0) begin
                $error("unexpected result: status %0d adopted_id %0d",
                       o_status, o_adopted_id);
                err_count++;
            end else begin
                want = outcome_q.pop_front();
                if (o_status !== want.status) begin
                    $error("status mismatch: expected %0d actual %0d",
                           want.status, o_status);
                    err_count++;
                end
                if (o_adopted_id !== want.adopted_id) begin
                    $error("adopted_id mismatch: expected %0d actual %0d",
                           want.adopted_id, o_adopted_id);
                    err_count++;
                end
            end
        end
    end

    initial begin
        for (int c = 0; c < 2; c++) begin
            head[c]  = 0;
            count[c] = 0;
        end
        next_stamp = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_requests();
        test_class_order();
        test_full_queue();
        test_random_traffic();

        repeat (8) @(posedge i_clk);
        if (outcome_q.size() != 0) begin
            $error("%0d results never arrived", outcome_q.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("two_class_fifo_oldest_first test passed");
        end else begin
            $display("two_class_fifo_oldest_first test failed");
        end
        $finish;
    end

endmodule

### files.f
design/tcf_pkg.sv
design/tcf_ctrl.sv
design/tcf_datapath.sv
design/two_class_fifo_oldest_first.sv
verif/testbench.sv
